// ===== sv/rpec_pkg.sv =====
// rpec_pkg: shared widths and types for the range prefix expansion counter
// no dependencies; imported by the channel interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package rpec_pkg;

  // width of the key space that ranges are counted in
  localparam int KEY_WIDTH = 32;
  // width of the range fields and of the result words
  localparam int DATA_W    = 32;
  // a range splits into at most 2*KEY_WIDTH-2 prefixes
  localparam int CNT_W     = $clog2(2 * KEY_WIDTH);

  typedef logic [DATA_W-1:0]    word_t;
  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [CNT_W-1:0]     cnt_t;

endpackage

`default_nettype wire

// ===== sv/rpec_in_if.sv =====
// rpec_in_if: valid/ready channel carrying one field range beat
// depends on rpec_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rpec_in_if;
  import rpec_pkg::*;

  logic  valid;
  logic  ready;
  word_t range_low;
  word_t range_high;
  logic  end_of_rule;
  logic  end_of_set;

  modport source (
    output valid, range_low, range_high, end_of_rule, end_of_set,
    input  ready
  );

  modport sink (
    input  valid, range_low, range_high, end_of_rule, end_of_set,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/rpec_out_if.sv =====
// rpec_out_if: valid/ready channel carrying one finished rule result beat
// depends on rpec_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rpec_out_if;
  import rpec_pkg::*;

  logic  valid;
  logic  ready;
  word_t rule_prefixes;
  word_t total_prefixes;
  logic  set_done;
  logic  overflow_seen;

  modport source (
    output valid, rule_prefixes, total_prefixes, set_done, overflow_seen,
    input  ready
  );

  modport sink (
    input  valid, rule_prefixes, total_prefixes, set_done, overflow_seen,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/range_prefix_expansion_counter.sv =====
// range_prefix_expansion_counter: top level, prefix count sequencer with
// shared multiply and accumulate; depends on rpec_pkg, rpec_in_if, rpec_out_if
`timescale 1ns / 1ps
`default_nettype none

// Takes one field range beat at a time and counts the aligned prefixes that
// exactly cover it, walking the key one bit level per cycle: the low end is
// rounded up and the high end down at each level, then both shift right.
// Counts of the ranges of a rule are multiplied into a rule product; at the
// end of a rule that product is added to the set total and one result beat
// is sent. An empty range (low above high) counts zero. Product and total
// wrap modulo 2^32 and overflow_seen is sticky within a set; end_of_set
// also closes the open rule and clears the total after its result.
// A beat that closes a rule walks its bit levels in ST_COUNT (skipped for an
// empty range), then passes through ST_MUL and ST_ACC; a beat that leaves
// its rule open returns to idle after ST_MUL. The level walk runs through
// the single increment/compare unit. in.ready is high only while the
// sequencer is idle; a finished result holds the sequencer in its
// accumulate step while the previous result is still held in the output
// register and not taken by out_o.ready.
module range_prefix_expansion_counter (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rpec_in_if.sink   in_i,
  rpec_out_if.source out_o
);
  import rpec_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_COUNT = 4'b0010,
    ST_MUL   = 4'b0100,
    ST_ACC   = 4'b1000
  } state_e;

  localparam int PROD_W = DATA_W + CNT_W;

  state_e state_q, state_d;
  key_t   lo_q, lo_d, hi_q, hi_d;
  cnt_t   cnt_q, cnt_d;
  logic   eor_q, eor_d, eos_q, eos_d;
  word_t  rule_product_q, rule_product_d;
  word_t  set_total_q, set_total_d;
  logic   wrap_q, wrap_d;

  logic   out_valid_q, out_valid_d;
  word_t  out_rule_q, out_rule_d;
  word_t  out_total_q, out_total_d;
  logic   out_done_q, out_done_d;
  logic   out_ovf_q, out_ovf_d;

  // level walk unit
  logic   lo_odd, hi_even, lo_eq_hi, hi_cnt, walk_fin;
  key_t   lo_inc, hi_dec;

  // multiply and accumulate unit
  logic [PROD_W-1:0] prod_full;
  logic [DATA_W:0]   sum_full;
  logic              out_free;

  // one bit level: round low up, high down, count the pieces cut off
  always_comb begin
    lo_odd   = lo_q[0];
    hi_even  = ~hi_q[0];
    lo_eq_hi = (lo_q == hi_q);
    lo_inc   = lo_q + key_t'(lo_odd);
    hi_dec   = hi_q - key_t'(hi_even);
    hi_cnt   = hi_even & ~(lo_odd & lo_eq_hi);
    walk_fin = (lo_odd & lo_eq_hi) | (hi_even & (lo_inc == hi_q));
  end

  assign prod_full = PROD_W'(rule_product_q) * PROD_W'(cnt_q);
  assign sum_full  = {1'b0, set_total_q} + {1'b0, rule_product_q};
  assign out_free  = ~out_valid_q | out_o.ready;

  assign in_i.ready = (state_q == ST_IDLE);

  // sequencer and datapath next state
  always_comb begin
    state_d        = state_q;
    lo_d           = lo_q;
    hi_d           = hi_q;
    cnt_d          = cnt_q;
    eor_d          = eor_q;
    eos_d          = eos_q;
    rule_product_d = rule_product_q;
    set_total_d    = set_total_q;
    wrap_d         = wrap_q;
    out_valid_d    = out_valid_q & ~out_o.ready;
    out_rule_d     = out_rule_q;
    out_total_d    = out_total_q;
    out_done_d     = out_done_q;
    out_ovf_d      = out_ovf_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          lo_d  = in_i.range_low[KEY_WIDTH-1:0];
          hi_d  = in_i.range_high[KEY_WIDTH-1:0];
          eor_d = in_i.end_of_rule;
          eos_d = in_i.end_of_set;
          cnt_d = '0;
          // empty range skips the walk with a zero count
          if (in_i.range_low[KEY_WIDTH-1:0] > in_i.range_high[KEY_WIDTH-1:0]) begin
            state_d = ST_MUL;
          end else begin
            state_d = ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        cnt_d = cnt_q + cnt_t'(lo_odd) + cnt_t'(hi_cnt);
        lo_d  = lo_inc >> 1;
        hi_d  = hi_dec >> 1;
        if (walk_fin) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        rule_product_d = prod_full[DATA_W-1:0];
        if (|prod_full[PROD_W-1:DATA_W]) begin
          wrap_d = 1'b1;
        end
        if (eor_q || eos_q) begin
          state_d = ST_ACC;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ACC: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_rule_d     = rule_product_q;
          out_total_d    = sum_full[DATA_W-1:0];
          out_done_d     = eos_q;
          out_ovf_d      = wrap_q | sum_full[DATA_W];
          rule_product_d = word_t'(1);
          if (eos_q) begin
            set_total_d = '0;
            wrap_d      = 1'b0;
          end else begin
            set_total_d = sum_full[DATA_W-1:0];
            wrap_d      = wrap_q | sum_full[DATA_W];
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      rule_product_q <= word_t'(1);
      set_total_q    <= '0;
      wrap_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      rule_product_q <= rule_product_d;
      set_total_q    <= set_total_d;
      wrap_q         <= wrap_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    cnt_q       <= cnt_d;
    eor_q       <= eor_d;
    eos_q       <= eos_d;
    out_rule_q  <= out_rule_d;
    out_total_q <= out_total_d;
    out_done_q  <= out_done_d;
    out_ovf_q   <= out_ovf_d;
  end

  // result beat
  assign out_o.valid          = out_valid_q;
  assign out_o.rule_prefixes  = out_rule_q;
  assign out_o.total_prefixes = out_total_q;
  assign out_o.set_done       = out_done_q;
  assign out_o.overflow_seen  = out_ovf_q;

endmodule

`default_nettype wire
